>>> design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies; expects signals named clock and reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge, off during reset
`define CLAE_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, off during reset
`define CLAE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> design/clae_pkg.sv
// constants and types for the circular log with age expiry
// no dependencies
package clae_pkg;

   localparam int LOG_DEPTH     = 4096;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int PTR_W         = $clog2(LOG_DEPTH);

   localparam logic [1:0] MODE_LOG   = 2'd0;
   localparam logic [1:0] MODE_PRUNE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   typedef struct packed {
      logic [31:0]              start;
      logic [31:0]              interval;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } record_type;

endpackage

>>> design/circular_log_with_age_expiry.sv
// top level of the circular log with age expiry
// depends on clae_pkg and assert_macros.svh
`include "assert_macros.svh"

// Circular log of timed records with overwrite of the oldest and age expiry.
// Command channel: a transfer happens at a rising edge with start high and
// busy low; req_mode selects log (write then prune), prune only, or read.
// Result channel: one result per command, shown for exactly one cycle with
// rsp_strobe high; the receiver takes it unconditionally.
// csr_we writes max_age from csr_wdata at any edge; users, not the block, keep it to idle.
// Resources: one record memory port read per step, and one shared age unit
// (add start+interval, then subtract from now and compare to max_age).
//   log:    a write step, then a prune as below
//   prune:  read the tail, sum, check; repeat per expired record; empty log ends at the read
//   read:   read the slot, then output it (a miss ends at the read)
//   mode 3: result registered straight from idle
// busy is high from the cycle after the transfer up to the cycle before the
// strobe; an unused-mode command never raises it. The next command can
// transfer at the edge that takes the result, so commands never overlap.
// Reset clears head, tail, the logged total and max_age (to its maximum);
// the record memory is not cleared, slots are only read after being written.
module circular_log_with_age_expiry
   import clae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_current_time,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_interval,
   input  logic [63:0] req_payload,
   input  logic [11:0] req_read_index,
   // result channel
   output logic        rsp_strobe,
   output logic        rsp_entry_valid,
   output logic [31:0] rsp_entry_start,
   output logic [31:0] rsp_entry_interval,
   output logic [63:0] rsp_entry_payload,
   output logic [11:0] rsp_stored_count,
   output logic        rsp_overwrote_oldest,
   output logic [11:0] rsp_expired_count,
   output logic [31:0] rsp_total_logged,
   // configuration
   input  logic        csr_we,
   input  logic [30:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_PRUNE_RD,
      ST_PRUNE_SUM,
      ST_PRUNE_CHK,
      ST_READ_RD,
      ST_READ_OUT
   } state_type;

   state_type state_ff;

   // ring cursors and counters
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] tail_ff;
   logic [31:0]      total_ff;
   logic [30:0]      max_age_ff;
   logic [PTR_W-1:0] expired_ff;
   logic             overwrote_ff;

   // latched command fields
   logic [31:0]              now_ff;
   logic [31:0]              start_time_ff;
   logic [31:0]              interval_ff;
   logic [PAYLOAD_WIDTH-1:0] payload_ff;
   logic [11:0]              index_ff;

   // shared age unit
   logic [31:0] end_ff;
   logic [31:0] age;
   logic        too_old;

   // record memory
   record_type       mem [LOG_DEPTH];
   record_type       mem_q_ff;
   logic [PTR_W-1:0] rd_addr;
   logic             mem_we;
   record_type       wr_rec;

   // registered result
   logic        rsp_strobe_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_start_ff;
   logic [31:0] rsp_interval_ff;
   logic [63:0] rsp_payload_ff;
   logic [11:0] rsp_count_ff;
   logic        rsp_overwrote_ff;
   logic [11:0] rsp_expired_ff;
   logic [31:0] rsp_total_ff;

   logic [PTR_W-1:0] held;
   logic [PTR_W-1:0] head_next;
   logic             accept;
   logic             index_hit;

   assign accept    = start && (state_ff == ST_IDLE);
   assign held      = head_ff - tail_ff;
   assign head_next = head_ff + PTR_W'(1);
   assign index_hit = 32'(index_ff) < 32'(held);

   // age is a signed 32-bit difference; negative ages never expire
   assign age     = now_ff - end_ff;
   assign too_old = !age[31] && (age[30:0] > max_age_ff);

   // read the tail while pruning, the indexed slot while reading
   always_comb begin
      if (state_ff == ST_READ_RD) begin
         rd_addr = PTR_W'(32'(tail_ff) + 32'(index_ff));
      end else begin
         rd_addr = tail_ff;
      end
   end

   assign mem_we          = (state_ff == ST_WRITE);
   assign wr_rec.start    = start_time_ff;
   assign wr_rec.interval = interval_ff;
   assign wr_rec.payload  = payload_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[head_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= 31'h7FFF_FFFF;
      end else if (csr_we) begin
         max_age_ff <= csr_wdata;
      end
   end

   // sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  now_ff        <= req_current_time;
                  start_time_ff <= req_start_time;
                  interval_ff   <= req_interval;
                  payload_ff    <= req_payload[PAYLOAD_WIDTH-1:0];
                  index_ff      <= req_read_index;
                  expired_ff    <= '0;
                  overwrote_ff  <= 1'b0;
                  unique case (req_mode)
                     MODE_LOG:   state_ff <= ST_WRITE;
                     MODE_PRUNE: state_ff <= ST_PRUNE_RD;
                     MODE_READ:  state_ff <= ST_READ_RD;
                     default: begin
                        // unused mode: report the state untouched
                        rsp_strobe_ff    <= 1'b1;
                        rsp_valid_ff     <= 1'b0;
                        rsp_start_ff     <= '0;
                        rsp_interval_ff  <= '0;
                        rsp_payload_ff   <= '0;
                        rsp_count_ff     <= 12'(held);
                        rsp_overwrote_ff <= 1'b0;
                        rsp_expired_ff   <= '0;
                        rsp_total_ff     <= total_ff;
                     end
                  endcase
               end
            end
            ST_WRITE: begin
               head_ff  <= head_next;
               total_ff <= total_ff + 32'd1;
               // ring full: drop the oldest record
               if (head_next == tail_ff) begin
                  tail_ff      <= tail_ff + PTR_W'(1);
                  overwrote_ff <= 1'b1;
               end
               state_ff <= ST_PRUNE_RD;
            end
            ST_PRUNE_RD: begin
               if (held == '0) begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_valid_ff     <= 1'b0;
                  rsp_start_ff     <= '0;
                  rsp_interval_ff  <= '0;
                  rsp_payload_ff   <= '0;
                  rsp_count_ff     <= 12'(held);
                  rsp_overwrote_ff <= overwrote_ff;
                  rsp_expired_ff   <= 12'(expired_ff);
                  rsp_total_ff     <= total_ff;
                  state_ff         <= ST_IDLE;
               end else begin
                  state_ff <= ST_PRUNE_SUM;
               end
            end
            ST_PRUNE_SUM: begin
               end_ff   <= mem_q_ff.start + mem_q_ff.interval;
               state_ff <= ST_PRUNE_CHK;
            end
            ST_PRUNE_CHK: begin
               if (too_old) begin
                  tail_ff    <= tail_ff + PTR_W'(1);
                  expired_ff <= expired_ff + PTR_W'(1);
                  state_ff   <= ST_PRUNE_RD;
               end else begin
                  rsp_strobe_ff    <= 1'b1;
                  rsp_valid_ff     <= 1'b0;
                  rsp_start_ff     <= '0;
                  rsp_interval_ff  <= '0;
                  rsp_payload_ff   <= '0;
                  rsp_count_ff     <= 12'(held);
                  rsp_overwrote_ff <= overwrote_ff;
                  rsp_expired_ff   <= 12'(expired_ff);
                  rsp_total_ff     <= total_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            ST_READ_RD: begin
               if (index_hit) begin
                  state_ff <= ST_READ_OUT;
               end else begin
                  // index beyond the stored records
                  rsp_strobe_ff    <= 1'b1;
                  rsp_valid_ff     <= 1'b0;
                  rsp_start_ff     <= '0;
                  rsp_interval_ff  <= '0;
                  rsp_payload_ff   <= '0;
                  rsp_count_ff     <= 12'(held);
                  rsp_overwrote_ff <= 1'b0;
                  rsp_expired_ff   <= '0;
                  rsp_total_ff     <= total_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            ST_READ_OUT: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_valid_ff     <= 1'b1;
               rsp_start_ff     <= mem_q_ff.start;
               rsp_interval_ff  <= mem_q_ff.interval;
               rsp_payload_ff   <= 64'(mem_q_ff.payload);
               rsp_count_ff     <= 12'(held);
               rsp_overwrote_ff <= 1'b0;
               rsp_expired_ff   <= '0;
               rsp_total_ff     <= total_ff;
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_entry_valid      = rsp_valid_ff;
   assign rsp_entry_start      = rsp_start_ff;
   assign rsp_entry_interval   = rsp_interval_ff;
   assign rsp_entry_payload    = rsp_payload_ff;
   assign rsp_stored_count     = rsp_count_ff;
   assign rsp_overwrote_oldest = rsp_overwrote_ff;
   assign rsp_expired_count    = rsp_expired_ff;
   assign rsp_total_logged     = rsp_total_ff;

   // every command that kept the block busy ends in a result
   `CLAE_ASSERT_IMPLY(a_busy_ends_in_result, $fell(busy), rsp_strobe)
   // a dropped oldest record means the ring was full before pruning
   `CLAE_ASSERT_IMPLY(a_overwrite_full,
      rsp_strobe && rsp_overwrote_oldest,
      12'(rsp_stored_count + rsp_expired_count) == 12'(LOG_DEPTH - 1))
   // a miss or a non-read result carries no record
   `CLAE_ASSERT_IMPLY(a_invalid_zero, rsp_strobe && !rsp_entry_valid,
      (rsp_entry_start == '0) && (rsp_entry_interval == '0) && (rsp_entry_payload == '0))
   // each record write bumps the logged total exactly once
   `CLAE_ASSERT_NEXT(a_total_step, state_ff == ST_WRITE,
      total_ff == $past(total_ff) + 32'd1)

endmodule
